// ----- rtl/core/dst_pkg.sv -----
// ----------------------------------------------------------------------------
// dst_pkg
// types, register codes, constants and helpers shared by the stopwatch card
// ----------------------------------------------------------------------------
package dst_pkg;

   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_WRITE = 2'd2,
      FUNC_RESET = 2'd3
   } func_type;

   // bus register codes
   localparam logic [3:0] REG_CLEAR   = 4'd0;
   localparam logic [3:0] REG_STATUS  = 4'd1;
   localparam logic [3:0] REG_START   = 4'd1;
   localparam logic [3:0] REG_STOP    = 4'd2;
   localparam logic [3:0] REG_RATE    = 4'd4;
   localparam logic [3:0] REG_DISPLAY = 4'd5;
   localparam logic [3:0] REG_T1_B0   = 4'd8;
   localparam logic [3:0] REG_T1_B3   = 4'd11;
   localparam logic [3:0] REG_T2_B0   = 4'd12;
   localparam logic [3:0] REG_T2_B3   = 4'd15;

   localparam logic [11:0] DEVSEL_MASK = 12'h0F00;
   localparam logic [31:0] BLANK_WORD  = 32'hFFFF_FFFF;
   localparam logic [31:0] STEP_FAST   = 32'd20;
   localparam logic [31:0] STEP_MID    = 32'd7;
   localparam logic [31:0] STEP_SLOW   = 32'd1;

   typedef struct packed {
      logic [1:0]  func;
      logic [11:0] bus_addr;
      logic [7:0]  write_data;
   } item_type;

   typedef struct packed {
      logic        read_valid;
      logic [7:0]  read_data;
      logic        display_valid;
      logic [31:0] display_word;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } batch_type;

   function automatic logic [31:0] second_step(input logic [1:0] rate);
      logic [31:0] step;
      case (rate)
         2'd0:    step = STEP_SLOW;
         2'd1:    step = STEP_MID;
         default: step = STEP_FAST;
      endcase
      return step;
   endfunction

   function automatic logic [7:0] byte_of(input logic [31:0] word, input logic [1:0] sel);
      logic [31:0] shifted;
      shifted = word >> {sel, 3'b000};
      return shifted[7:0];
   endfunction

   function automatic result_type read_result(input logic [7:0] data);
      result_type r;
      r = '0;
      r.read_valid = 1'b1;
      r.read_data  = data;
      return r;
   endfunction

   function automatic result_type push_result(input logic [31:0] word);
      result_type r;
      r = '0;
      r.display_valid = 1'b1;
      r.display_word  = word;
      return r;
   endfunction

endpackage

// ----- rtl/core/dst_channels.sv -----
// ----------------------------------------------------------------------------
// dst channels
// valid/ready interfaces for the request and response transactions
// ----------------------------------------------------------------------------
interface dst_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [11:0] bus_addr;
   logic [7:0]  write_data;

   modport source (output valid, output func, output bus_addr, output write_data,
                   input ready);
   modport sink   (input valid, input func, input bus_addr, input write_data,
                   output ready);
endinterface

interface dst_rsp_if;
   logic        valid;
   logic        ready;
   logic        read_valid;
   logic [7:0]  read_data;
   logic        display_valid;
   logic [31:0] display_word;
   logic        last;

   modport source (output valid, output read_valid, output read_data,
                   output display_valid, output display_word, output last,
                   input ready);
   modport sink   (input valid, input read_valid, input read_data,
                   input display_valid, input display_word, input last,
                   output ready);
endinterface

// ----- rtl/core/dst_engine.sv -----
// ----------------------------------------------------------------------------
// dst_engine
// input register, timer state and single-pass decode of one transaction
// ----------------------------------------------------------------------------
module dst_engine (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  dst_pkg::item_type  in_item,
   output logic               in_ready,
   input  logic               out_free,
   output logic               batch_load,
   output dst_pkg::batch_type batch
);
   import dst_pkg::*;

   logic        stage_valid_ff, stage_valid_in;
   item_type    stage_item_ff;
   logic [31:0] live1_ff, live1_in, latch1_ff, latch1_in;
   logic [31:0] live2_ff, live2_in, latch2_ff, latch2_in;
   logic        run1_ff, run1_in, run2_ff, run2_in;
   logic [1:0]  rate_ff, rate_in;
   logic        disp_ff, disp_in;

   logic        devsel;
   logic [3:0]  reg_sel;
   logic [1:0]  mask;
   logic [31:0] lat1, lat2;

   assign batch_load     = stage_valid_ff && out_free;
   assign in_ready       = !stage_valid_ff || out_free;
   assign stage_valid_in = in_ready ? in_valid : stage_valid_ff;

   assign devsel  = (stage_item_ff.bus_addr & DEVSEL_MASK) == 12'd0;
   assign reg_sel = stage_item_ff.bus_addr[3:0];
   assign mask    = (stage_item_ff.write_data == 8'd0) ? 2'b11
                                                       : stage_item_ff.write_data[1:0];

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         stage_item_ff <= in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         live1_ff       <= '0;
         latch1_ff      <= '0;
         live2_ff       <= '0;
         latch2_ff      <= '0;
         run1_ff        <= 1'b0;
         run2_ff        <= 1'b0;
         rate_ff        <= '0;
         disp_ff        <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (batch_load) begin
            live1_ff  <= live1_in;
            latch1_ff <= latch1_in;
            live2_ff  <= live2_in;
            latch2_ff <= latch2_in;
            run1_ff   <= run1_in;
            run2_ff   <= run2_in;
            rate_ff   <= rate_in;
            disp_ff   <= disp_in;
         end
      end
   end

   always_comb begin
      live1_in  = live1_ff;
      latch1_in = latch1_ff;
      live2_in  = live2_ff;
      latch2_in = latch2_ff;
      run1_in   = run1_ff;
      run2_in   = run2_ff;
      rate_in   = rate_ff;
      disp_in   = disp_ff;
      lat1      = latch1_ff;
      lat2      = run2_ff ? live2_ff : latch2_ff;
      batch     = '0;

      unique case (func_type'(stage_item_ff.func))
         FUNC_TICK: begin
            if (run1_ff) live1_in = live1_ff + STEP_FAST;
            if (run2_ff) live2_in = live2_ff + second_step(rate_ff);
         end
         FUNC_READ: begin
            if (devsel) begin
               unique case (reg_sel) inside
                  REG_STATUS: begin
                     batch.count = 2'd1;
                     batch.first = read_result({run1_ff, run2_ff, 6'b0});
                  end
                  REG_RATE: begin
                     batch.count = 2'd1;
                     batch.first = read_result({rate_ff, 6'b0});
                  end
                  [REG_T1_B0:REG_T1_B3]: begin
                     if (reg_sel == REG_T1_B0 && run1_ff) lat1 = live1_ff;
                     latch1_in   = lat1;
                     batch.count = 2'd1;
                     batch.first = read_result(byte_of(lat1, reg_sel[1:0]));
                  end
                  [REG_T2_B0:REG_T2_B3]: begin
                     if (reg_sel != REG_T2_B0) lat2 = latch2_ff;
                     latch2_in = lat2;
                     if (reg_sel == REG_T2_B0 && run2_ff && disp_ff) begin
                        batch.count  = 2'd2;
                        batch.first  = push_result(lat2);
                        batch.second = read_result(byte_of(lat2, reg_sel[1:0]));
                     end else begin
                        batch.count = 2'd1;
                        batch.first = read_result(byte_of(lat2, reg_sel[1:0]));
                     end
                  end
                  default: ;
               endcase
            end
         end
         FUNC_WRITE: begin
            if (devsel) begin
               unique case (reg_sel)
                  REG_CLEAR: begin
                     if (mask[0]) begin
                        live1_in  = '0;
                        latch1_in = '0;
                     end
                     if (mask[1]) begin
                        live2_in  = '0;
                        latch2_in = '0;
                        if (disp_ff) begin
                           batch.count = 2'd1;
                           batch.first = push_result('0);
                        end
                     end
                  end
                  REG_START: begin
                     if (mask[0]) begin
                        live1_in = latch1_ff;
                        run1_in  = 1'b1;
                     end
                     if (mask[1]) begin
                        live2_in = latch2_ff;
                        run2_in  = 1'b1;
                     end
                  end
                  REG_STOP: begin
                     if (mask[0]) begin
                        if (run1_ff) latch1_in = live1_ff;
                        run1_in = 1'b0;
                     end
                     if (mask[1]) begin
                        latch2_in = lat2;
                        run2_in   = 1'b0;
                        if (disp_ff) begin
                           batch.count  = run2_ff ? 2'd2 : 2'd1;
                           batch.first  = push_result(lat2);
                           batch.second = push_result(lat2);
                        end
                     end
                  end
                  REG_RATE: begin
                     rate_in = stage_item_ff.write_data[1:0];
                  end
                  REG_DISPLAY: begin
                     if (stage_item_ff.write_data != 8'd0) begin
                        disp_in      = 1'b1;
                        latch2_in    = lat2;
                        batch.count  = run2_ff ? 2'd2 : 2'd1;
                        batch.first  = push_result(lat2);
                        batch.second = push_result(lat2);
                     end else begin
                        disp_in     = 1'b0;
                        batch.count = 2'd1;
                        batch.first = push_result(BLANK_WORD);
                     end
                  end
                  default: ;
               endcase
            end
         end
         FUNC_RESET: begin
            live1_in    = '0;
            latch1_in   = '0;
            live2_in    = '0;
            latch2_in   = '0;
            run1_in     = 1'b0;
            run2_in     = 1'b0;
            rate_in     = '0;
            disp_in     = 1'b0;
            batch.count = 2'd1;
            batch.first = push_result(BLANK_WORD);
         end
      endcase

      batch.first.last  = (batch.count == 2'd1);
      batch.second.last = (batch.count == 2'd2);
   end

endmodule

// ----- rtl/core/dst_result_buffer.sv -----
// ----------------------------------------------------------------------------
// dst_result_buffer
// two-slot result register that hands out the results of one transaction
// ----------------------------------------------------------------------------
module dst_result_buffer (
   input  logic               clock,
   input  logic               reset,
   input  logic               batch_load,
   input  dst_pkg::batch_type batch,
   output logic               out_free,
   dst_rsp_if.source          rsp
);
   import dst_pkg::*;

   logic       pend0_ff, pend0_in, pend1_ff, pend1_in;
   result_type slot0_ff, slot1_ff, shown;
   logic       taken;

   assign shown    = pend0_ff ? slot0_ff : slot1_ff;
   assign taken    = rsp.valid && rsp.ready;
   assign out_free = !(pend0_ff || pend1_ff) || (rsp.ready && (pend0_ff ^ pend1_ff));

   assign rsp.valid         = pend0_ff || pend1_ff;
   assign rsp.read_valid    = shown.read_valid;
   assign rsp.read_data     = shown.read_data;
   assign rsp.display_valid = shown.display_valid;
   assign rsp.display_word  = shown.display_word;
   assign rsp.last          = shown.last;

   always_comb begin
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      if (batch_load) begin
         pend0_in = batch.count != 2'd0;
         pend1_in = batch.count == 2'd2;
      end else if (taken) begin
         if (pend0_ff) pend0_in = 1'b0;
         else pend1_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend0_ff <= 1'b0;
         pend1_ff <= 1'b0;
      end else begin
         pend0_ff <= pend0_in;
         pend1_ff <= pend1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (batch_load) begin
         slot0_ff <= batch.first;
         slot1_ff <= batch.second;
      end
   end

endmodule

// ----- rtl/core/dual_stopwatch_timer_card.sv -----
// ----------------------------------------------------------------------------
// dual_stopwatch_timer_card
// two 32-bit stopwatch timers behind sixteen bus registers
// ----------------------------------------------------------------------------
// req_in carries one transaction per event: a microsecond tick, a bus read,
// a bus write or a card reset, with the bus address and write byte.
// rsp_out carries the results of each transaction in order: read bytes and
// display pushes, with last set on the final result of the transaction.
// a tick, an access outside device select or an unused register gives none.
// a transaction is registered in the input register at acceptance, decoded
// from there and its results are registered in the result buffer for rsp_out.
// throughput: one transaction per cycle while each gives at most one result
// and rsp_out is not stalled; a transaction with two results holds the result
// register until both have gone out through the single result port.
// reset (synchronous, active high) clears both timers, the frequency and the
// display flag, and empties the pipeline.
// when rsp_out is stalled the pending results hold, the input register
// fills and then req_in.ready drops until the results are taken.
// ----------------------------------------------------------------------------
module dual_stopwatch_timer_card (
   input  logic      clock,
   input  logic      reset,
   dst_req_if.sink   req_in,
   dst_rsp_if.source rsp_out
);
   import dst_pkg::*;

   item_type  item;
   batch_type batch;
   logic      out_free;
   logic      batch_load;
   logic      in_ready;

   assign item.func       = req_in.func;
   assign item.bus_addr   = req_in.bus_addr;
   assign item.write_data = req_in.write_data;
   assign req_in.ready    = in_ready;

   dst_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_in.valid),
      .in_item    (item),
      .in_ready   (in_ready),
      .out_free   (out_free),
      .batch_load (batch_load),
      .batch      (batch)
   );

   dst_result_buffer u_result_buffer (
      .clock      (clock),
      .reset      (reset),
      .batch_load (batch_load),
      .batch      (batch),
      .out_free   (out_free),
      .rsp        (rsp_out)
   );

endmodule
